[hdl/ahclp_pkg.sv]
// Package for the ASCII-hex CAN line parser: constants, result and control types,
// and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ahclp_pkg;

  // Sizing of the frame and the digit store.
  localparam int MAX_DATA_BYTES = 8;
  localparam int NIBBLE_DEPTH   = 24;
  localparam int NIB_IDX_W      = $clog2(NIBBLE_DEPTH);

  // Character codes and fixed values.
  localparam logic [7:0] EOL_RESET     = 8'h0D;
  localparam logic [7:0] PROMPT_CHAR   = 8'h3E;
  localparam logic [7:0] NULL_CHAR     = 8'h00;
  localparam logic [7:0] COUNT_MAX     = 8'hFF;
  localparam logic [7:0] STD_ID_DIGITS = 8'd3;
  localparam logic [7:0] EXT_ID_DIGITS = 8'd8;
  localparam logic [7:0] DATA_DIGITS_MAX = 8'(2 * MAX_DATA_BYTES);

  typedef enum logic [1:0] {
    KIND_FRAME    = 2'd0,
    KIND_CMD      = 2'd1,
    KIND_PROMPT   = 2'd2,
    KIND_OVERLONG = 2'd3
  } kind_t;

  typedef logic [NIBBLE_DEPTH-1:0][3:0] nib_vec_t;

  typedef struct packed {
    kind_t       kind;
    logic        id_extended;
    logic [31:0] frame_id;
    logic [3:0]  data_count;
    logic [63:0] data_bytes;
    logic [7:0]  line_length;
  } result_t;

  // State of the line being collected.
  typedef struct packed {
    logic [7:0] count;
    logic       non_hex;
    logic       odd;
  } line_status_t;

  // Update requested of the line store for one accepted byte.
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       is_hex;
    logic [3:0] nibble;
  } line_ctrl_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/ahclp_if.sv]
// Handshake channels of the line parser: received bytes and decoded results.
// Depends on ahclp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ahclp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ahclp_result_if;
  import ahclp_pkg::*;

  logic        valid;
  logic        ready;
  kind_t       kind;
  logic        id_extended;
  logic [31:0] frame_id;
  logic [3:0]  data_count;
  logic [63:0] data_bytes;
  logic [7:0]  line_length;

  modport source (output valid, output kind, output id_extended, output frame_id,
                  output data_count, output data_bytes, output line_length, input ready);
  modport sink (input valid, input kind, input id_extended, input frame_id,
                input data_count, input data_bytes, input line_length, output ready);
endinterface

`default_nettype wire

[hdl/ahclp_line_state.sv]
// Line store of the parser: character count, non-hex flag, length parity and
// the per-position hex digit store. Depends on ahclp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ahclp_line_state (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  ahclp_pkg::line_ctrl_t   ctrl,
  output ahclp_pkg::line_status_t status,
  output ahclp_pkg::nib_vec_t     nibbles
);
  import ahclp_pkg::*;

  logic [7:0] count;
  logic       non_hex;
  logic       odd;
  nib_vec_t   store;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= 8'd0;
      non_hex <= 1'b0;
      odd     <= 1'b0;
    end else if (accept && ctrl.clear) begin
      count   <= 8'd0;
      non_hex <= 1'b0;
      odd     <= 1'b0;
    end else if (accept && ctrl.append) begin
      if (!ctrl.is_hex) begin
        non_hex <= 1'b1;
      end
      if (count != COUNT_MAX) begin
        count <= count + 8'd1;
      end
      odd <= !odd;
    end
  end

  // The digit store is undefined until written; only positions written earlier in
  // the current line are ever used.
  always_ff @(posedge clk) begin
    if (accept && ctrl.append && ctrl.is_hex && (count < 8'(NIBBLE_DEPTH))) begin
      store[count[NIB_IDX_W-1:0]] <= ctrl.nibble;
    end
  end

  assign status  = '{count: count, non_hex: non_hex, odd: odd};
  assign nibbles = store;

endmodule

`default_nettype wire

[hdl/ahclp_decode.sv]
// Decoder of the parser: classifies one byte against the current line and builds
// the result and the store update. Depends on ahclp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ahclp_decode (
  input  logic [7:0]              rx_byte,
  input  logic [7:0]              eol_char,
  input  ahclp_pkg::line_status_t status,
  input  ahclp_pkg::nib_vec_t     nibbles,
  output logic                    has_result,
  output ahclp_pkg::result_t      result,
  output ahclp_pkg::line_ctrl_t   ctrl
);
  import ahclp_pkg::*;

  logic        is_null;
  logic        is_eol;
  logic        is_prompt;
  logic [4:0]  hex;
  logic [7:0]  id_digits;
  logic [7:0]  data_digits;
  logic [3:0]  byte_count;
  logic        overlong;
  logic [31:0] fid_std;
  logic [31:0] fid_ext;
  logic [63:0] data_std;
  logic [63:0] data_ext;
  logic [63:0] data_sel;

  function automatic logic [3:0] nib(input nib_vec_t v, input int pos);
    return (pos < NIBBLE_DEPTH) ? v[pos] : 4'h0;
  endfunction

  assign is_null   = (rx_byte == NULL_CHAR);
  assign is_eol    = !is_null && (rx_byte == eol_char);
  assign is_prompt = !is_null && !is_eol && (status.count == 8'd0) && (rx_byte == PROMPT_CHAR);
  assign hex       = hex_value(rx_byte);

  assign ctrl.clear  = is_eol || is_prompt;
  assign ctrl.append = !is_null && !is_eol && !is_prompt;
  assign ctrl.is_hex = hex[4];
  assign ctrl.nibble = hex[3:0];

  assign id_digits   = status.odd ? STD_ID_DIGITS : EXT_ID_DIGITS;
  assign data_digits = status.count - id_digits;
  assign overlong    = (status.count == COUNT_MAX) || (data_digits > DATA_DIGITS_MAX);
  assign byte_count  = data_digits[4:1];

  always_comb begin
    fid_std = {20'b0, nib(nibbles, 0), nib(nibbles, 1), nib(nibbles, 2)};
    fid_ext = '0;
    for (int i = 0; i < 8; i++) begin
      fid_ext[31-4*i -: 4] = nib(nibbles, i);
    end
  end

  // Data bytes at both identifier lengths; bytes past the frame's count are zero.
  always_comb begin
    data_std = '0;
    data_ext = '0;
    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
      data_std[8*i +: 8] = {nib(nibbles, 3 + 2*i), nib(nibbles, 4 + 2*i)};
      data_ext[8*i +: 8] = {nib(nibbles, 8 + 2*i), nib(nibbles, 9 + 2*i)};
    end
    data_sel = status.odd ? data_std : data_ext;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= byte_count) begin
        data_sel[8*i +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    result     = '0;
    has_result = 1'b0;
    if (is_prompt) begin
      has_result  = 1'b1;
      result.kind = KIND_PROMPT;
    end else if (is_eol && (status.count != 8'd0)) begin
      has_result         = 1'b1;
      result.line_length = status.count;
      if (status.non_hex || (status.count < id_digits)) begin
        result.kind = KIND_CMD;
      end else begin
        result.id_extended = !status.odd;
        result.frame_id    = status.odd ? fid_std : fid_ext;
        if (overlong) begin
          result.kind = KIND_OVERLONG;
        end else begin
          result.kind       = KIND_FRAME;
          result.data_count = byte_count;
          result.data_bytes = data_sel;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ascii_hex_can_line_parser_top.sv]
// Top level of the ASCII-hex CAN line parser: configuration register, line store,
// decoder and result register. Depends on ahclp_pkg, ahclp_if, ahclp_line_state, ahclp_decode.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one received character per request on rx and turns each line
// into at most one result request on res. Null characters are dropped. A line closed
// by the end-of-line character (cfg register, 13 after reset) that holds only hex
// digits becomes a frame: odd length gives a three-digit standard identifier, even
// length an eight-digit extended one, and the digit pairs that follow are data bytes,
// first byte in bits 7:0. A line with any other character, or a hex line shorter than
// its identifier, is reported as a command response with its length only; a hex line
// with more than eight data bytes is reported as overlong. A '>' at the start of a
// line reports the prompt immediately. The decode runs from the line store straight
// into the result register, so a new character is taken in every cycle unless that
// register holds a result that the sink has not yet taken. Results leave in the cycle
// after the character that caused them. The configuration register must only be
// written while no character is being processed and no result is waiting.
module ascii_hex_can_line_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  ahclp_byte_if.sink     rx,
  ahclp_result_if.source res
);
  import ahclp_pkg::*;

  logic [7:0]   eol_reg;
  logic         accept;
  logic         has_result;
  result_t      result;
  result_t      res_data;
  logic         res_valid;
  line_ctrl_t   ctrl;
  line_status_t status;
  nib_vec_t     nibbles;

  // End-of-line character register.
  always_ff @(posedge clk) begin
    if (rst) begin
      eol_reg <= EOL_RESET;
    end else if (cfg_wr_en) begin
      eol_reg <= cfg_wr_data;
    end
  end

  // A character is taken whenever the result register is free or being emptied.
  assign rx.ready = !res_valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  ahclp_line_state u_line_state (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .ctrl    (ctrl),
    .status  (status),
    .nibbles (nibbles)
  );

  ahclp_decode u_decode (
    .rx_byte    (rx.rx_byte),
    .eol_char   (eol_reg),
    .status     (status),
    .nibbles    (nibbles),
    .has_result (has_result),
    .result     (result),
    .ctrl       (ctrl)
  );

  // Result register: loaded by a character that closes a line or shows the prompt.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && has_result) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      res_data <= result;
    end
  end

  assign res.valid       = res_valid;
  assign res.kind        = res_data.kind;
  assign res.id_extended = res_data.id_extended;
  assign res.frame_id    = res_data.frame_id;
  assign res.data_count  = res_data.data_count;
  assign res.data_bytes  = res_data.data_bytes;
  assign res.line_length = res_data.line_length;

`ifndef SYNTH
  // A null character leaves the line exactly as it was.
  a_null_keeps_line: assert property (@(posedge clk) disable iff (rst)
    (accept && (rx.rx_byte == NULL_CHAR)) |=> $stable(status))
    else $error("null character changed the line state");

  // Closing a line or reporting the prompt starts an empty line.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.clear) |=> (status.count == 8'd0 && !status.non_hex && !status.odd))
    else $error("line not emptied after it was closed");

  // A prompt report carries nothing but its kind.
  a_prompt_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.kind == KIND_PROMPT)) |->
      (res_data.frame_id == 32'd0 && res_data.line_length == 8'd0 &&
       res_data.data_count == 4'd0 && res_data.data_bytes == 64'd0))
    else $error("prompt report carries stray fields");

  // A frame never claims more data bytes than it can carry.
  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.kind == KIND_FRAME)) |->
      (res_data.data_count <= 4'(MAX_DATA_BYTES)))
    else $error("frame data count out of range");
`endif

endmodule

`default_nettype wire
